// ===== rtl/core/tmp_pkg.sv =====
`timescale 1ns / 1ps
package tmp_pkg;

	localparam int VALUE_WIDTH   = 32;
	localparam int FRACTION_BITS = 16;
	localparam int TW            = 50;

	typedef enum logic [2:0] {
		PH_BEFORE = 3'd0,
		PH_ACCEL  = 3'd1,
		PH_CRUISE = 3'd2,
		PH_DECEL  = 3'd3,
		PH_DONE   = 3'd4
	} phase_t;

	localparam logic [1:0] REG_START = 2'd0;
	localparam logic [1:0] REG_END   = 2'd1;
	localparam logic [1:0] REG_VEL   = 2'd2;
	localparam logic [1:0] REG_ACC   = 2'd3;

	typedef struct packed {
		logic          inst;
		logic          dir;
		logic [TW-1:0] t1;
		logic [TW-1:0] t2;
		logic [TW-1:0] dur;
		logic [31:0]   vp;
		logic [47:0]   p1;
		logic [47:0]   pc;
	} plan_t;

	localparam logic signed [63:0] SAT_HI = (64'sd1 <<< (VALUE_WIDTH - 1)) - 64'sd1;
	localparam logic signed [63:0] SAT_LO = -SAT_HI - 64'sd1;

	function automatic logic [31:0] sat_value(input logic signed [63:0] x);
		logic signed [63:0] y;
		begin
			y = x;
			if (x > SAT_HI) begin
				y = SAT_HI;
			end else if (x < SAT_LO) begin
				y = SAT_LO;
			end
			return y[31:0];
		end
	endfunction

endpackage

// ===== rtl/core/tmp_plan.sv =====
`timescale 1ns / 1ps
module tmp_plan import tmp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        kick,
	input  logic [31:0] start_position,
	input  logic [31:0] end_position,
	input  logic [30:0] max_velocity,
	input  logic [30:0] max_acceleration,
	output logic        busy,
	output plan_t       plan
);

	typedef enum logic [3:0] {
		S_IDLE, S_START, S_VV, S_CHK, S_QT, S_ROOT, S_VP, S_T1, S_T2,
		S_P1LO, S_P1HI, S_PCLO, S_PCHI, S_DIV
	} st_t;

	st_t          st_q, ret_q;
	logic         busy_q;
	plan_t        plan_q;
	logic [63:0]  num_q, quo_q, prod_q, rad_q;
	logic [30:0]  den_q;
	logic [31:0]  rem_q, d_q, root_q;
	logic [33:0]  srem_q;
	logic [5:0]   cnt_q;
	logic [79:0]  sum_q;

	logic [32:0]  div_sh;
	logic         div_ge;
	logic [35:0]  sq_sh, sq_trial;
	logic         sq_ge;
	logic signed [32:0] diff;
	logic [47:0]  mop;
	logic [79:0]  msum;
	logic [TW-1:0] t2n;

	assign div_sh   = {rem_q, num_q[63]};
	assign div_ge   = div_sh >= {2'b0, den_q};
	assign sq_sh    = {srem_q, rad_q[63:62]};
	assign sq_trial = {2'b0, root_q, 2'b01};
	assign sq_ge    = sq_sh >= sq_trial;
	assign diff     = {end_position[31], end_position} - {start_position[31], start_position};
	assign mop      = (st_q == S_P1HI) ? plan_q.t1[47:0] : 48'(plan_q.t2 - plan_q.t1);
	assign msum     = sum_q + ({48'b0, plan_q.vp} * {56'b0, mop[47:24]} << 24);
	assign t2n      = plan_q.t1 + quo_q[TW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= S_IDLE;
			ret_q       <= S_IDLE;
			busy_q      <= 1'b0;
			plan_q.inst <= 1'b1;
			plan_q.dir  <= 1'b1;
		end else if (kick) begin
			st_q   <= S_START;
			busy_q <= 1'b1;
		end else begin
			unique case (st_q)
				S_IDLE: begin
				end
				S_START: begin
					plan_q.dir <= ~diff[32];
					d_q        <= diff[32] ? 32'(-diff) : diff[31:0];
					prod_q     <= {2'b0, max_velocity} * {33'b0, max_velocity};
					if (max_velocity == '0 || max_acceleration == '0 || diff == '0) begin
						plan_q.inst <= 1'b1;
						busy_q      <= 1'b0;
						st_q        <= S_IDLE;
					end else begin
						plan_q.inst <= 1'b0;
						st_q        <= S_VV;
					end
				end
				S_VV: begin
					num_q <= prod_q;
					den_q <= max_acceleration;
					rem_q <= '0;
					cnt_q <= 6'd63;
					ret_q <= S_CHK;
					st_q  <= S_DIV;
				end
				S_DIV: begin
					rem_q <= div_ge ? 32'(div_sh - {2'b0, den_q}) : div_sh[31:0];
					quo_q <= {quo_q[62:0], div_ge};
					num_q <= {num_q[62:0], 1'b0};
					cnt_q <= cnt_q - 6'd1;
					if (cnt_q == '0) begin
						st_q <= ret_q;
					end
				end
				S_CHK: begin
					rem_q <= '0;
					cnt_q <= 6'd63;
					den_q <= max_acceleration;
					st_q  <= S_DIV;
					if ({32'b0, d_q} <= quo_q) begin
						num_q <= {d_q, 32'b0};
						ret_q <= S_QT;
					end else begin
						num_q <= {17'b0, max_velocity, 16'b0};
						d_q   <= d_q - quo_q[31:0];
						ret_q <= S_T1;
					end
				end
				S_QT: begin
					rad_q  <= quo_q;
					root_q <= '0;
					srem_q <= '0;
					cnt_q  <= 6'd31;
					st_q   <= S_ROOT;
				end
				S_ROOT: begin
					srem_q <= sq_ge ? 34'(sq_sh - sq_trial) : sq_sh[33:0];
					root_q <= {root_q[30:0], sq_ge};
					rad_q  <= {rad_q[61:0], 2'b00};
					cnt_q  <= cnt_q - 6'd1;
					if (cnt_q == '0) begin
						st_q <= S_VP;
					end
				end
				S_VP: begin
					plan_q.t1  <= TW'(root_q);
					plan_q.t2  <= TW'(root_q);
					plan_q.dur <= TW'({root_q, 1'b0});
					plan_q.vp  <= 32'(({33'b0, max_acceleration} * {32'b0, root_q}) >> FRACTION_BITS);
					st_q       <= S_P1LO;
				end
				S_T1: begin
					plan_q.t1 <= quo_q[TW-1:0];
					num_q     <= {16'b0, d_q, 16'b0};
					den_q     <= max_velocity;
					rem_q     <= '0;
					cnt_q     <= 6'd63;
					ret_q     <= S_T2;
					st_q      <= S_DIV;
				end
				S_T2: begin
					plan_q.t2  <= t2n;
					plan_q.dur <= t2n + plan_q.t1;
					plan_q.vp  <= {1'b0, max_velocity};
					st_q       <= S_P1LO;
				end
				S_P1LO: begin
					sum_q <= {48'b0, plan_q.vp} * {56'b0, plan_q.t1[23:0]};
					st_q  <= S_P1HI;
				end
				S_P1HI: begin
					plan_q.p1 <= msum[64:17];
					st_q      <= S_PCLO;
				end
				S_PCLO: begin
					sum_q <= {48'b0, plan_q.vp} * {56'b0, mop[23:0]};
					st_q  <= S_PCHI;
				end
				S_PCHI: begin
					plan_q.pc <= msum[63:16];
					busy_q    <= 1'b0;
					st_q      <= S_IDLE;
				end
				default: begin
					st_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy = busy_q;
	assign plan = plan_q;

endmodule

// ===== rtl/core/trapezoid_motion_profile_core.sv =====
`timescale 1ns / 1ps
// Trapezoidal motion profile generator, one axis, signed Q16.16.
// Configuration: cfg_write with cfg_index 0..3 writes start position, end
// position, velocity limit and acceleration limit. Each write restarts the
// profile planner (shared divider and square-root sequencer), which holds
// in_stall high while it works out the accelerate, cruise and end times.
// Input channel: one time stamp word per accepted cycle (in_valid, in_stall).
// Output channel: position, velocity, acceleration and phase word
// (out_valid, out_stall), one per input word, in order.
// A five-stage pipeline (s1 to s4 and the output register) sustains one word
// per cycle while the receiver does not stall; multipliers sit in s2 and s3.
// Reset clears the configuration registers to zero, empties the pipeline and
// leaves a zero-length profile, so every time stamp returns the end position.
// When the receiver stalls a valid output word, the whole pipeline holds and in_stall rises.
module trapezoid_motion_profile_core import tmp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_write,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] sample_time,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] position,
	output logic [31:0] velocity,
	output logic [31:0] acceleration,
	output logic [2:0]  phase
);

	logic [31:0] start_q, end_q;
	logic [30:0] vel_q, acc_q;
	logic        busy;
	plan_t       plan;

	logic        en, in_acc;
	logic        v_s1, v_s2, v_s3, v_s4, ov_q;
	phase_t      ph_s1, ph_s2, ph_s3, ph_s4, ph_n;
	logic [30:0] x_s1, x_s2, x_n;
	logic [31:0] va_s2, va_s3;
	logic [46:0] vq_s2, vq_s3;
	logic [45:0] h_s3;
	logic [TW-1:0] g_s4, g_n, tu, gsum;
	logic [31:0] vel_s4, v_n;
	logic [31:0] pos_q, velo_q, acco_q;
	phase_t      pho_q;

	logic signed [63:0] s64, e64, g64, v64, a64, pos_n, vel_n, acc_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= '0;
			end_q   <= '0;
			vel_q   <= '0;
			acc_q   <= '0;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_START: start_q <= cfg_data;
				REG_END:   end_q   <= cfg_data;
				REG_VEL:   vel_q   <= cfg_data[30:0];
				REG_ACC:   acc_q   <= cfg_data[30:0];
				default:   start_q <= start_q;
			endcase
		end
	end

	tmp_plan u_plan (
		.clk              (clk),
		.arst_n           (arst_n),
		.kick             (cfg_write),
		.start_position   (start_q),
		.end_position     (end_q),
		.max_velocity     (vel_q),
		.max_acceleration (acc_q),
		.busy             (busy),
		.plan             (plan)
	);

	assign en       = !ov_q || !out_stall;
	assign in_stall = busy || !en;
	assign in_acc   = in_valid && !in_stall;
	assign tu       = TW'(sample_time[30:0]);

	always_comb begin
		x_n  = sample_time[30:0];
		ph_n = PH_DONE;
		if (plan.inst) begin
			ph_n = PH_DONE;
		end else if (sample_time[31] || sample_time == '0) begin
			ph_n = PH_BEFORE;
		end else if (tu >= plan.dur) begin
			ph_n = PH_DONE;
		end else if (tu < plan.t1) begin
			ph_n = PH_ACCEL;
		end else if (tu < plan.t2) begin
			ph_n = PH_CRUISE;
			x_n  = 31'(tu - plan.t1);
		end else begin
			ph_n = PH_DECEL;
			x_n  = 31'(tu - plan.t2);
		end
	end

	always_comb begin
		gsum = plan.p1 + plan.pc + TW'(vq_s3);
		g_n  = '0;
		v_n  = '0;
		unique case (ph_s3)
			PH_ACCEL: begin
				g_n = TW'(h_s3);
				v_n = va_s3;
			end
			PH_CRUISE: begin
				g_n = TW'(plan.p1) + TW'(vq_s3);
				v_n = plan.vp;
			end
			PH_DECEL: begin
				g_n = (TW'(h_s3) > gsum) ? '0 : gsum - TW'(h_s3);
				v_n = (va_s3 > plan.vp) ? '0 : plan.vp - va_s3;
			end
			default: begin
				g_n = '0;
				v_n = '0;
			end
		endcase
	end

	always_comb begin
		s64   = 64'(signed'(start_q));
		e64   = 64'(signed'(end_q));
		g64   = signed'(64'(g_s4));
		v64   = signed'(64'(vel_s4));
		a64   = signed'(64'(acc_q));
		pos_n = plan.dir ? s64 + g64 : s64 - g64;
		vel_n = plan.dir ? v64 : -v64;
		acc_n = '0;
		unique case (ph_s4)
			PH_ACCEL: acc_n = plan.dir ? a64 : -a64;
			PH_DECEL: acc_n = plan.dir ? -a64 : a64;
			default:  acc_n = '0;
		endcase
		if (ph_s4 == PH_BEFORE) begin
			pos_n = s64;
			vel_n = '0;
		end else if (ph_s4 == PH_DONE) begin
			pos_n = e64;
			vel_n = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			ov_q <= 1'b0;
		end else if (en) begin
			v_s1 <= in_acc;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			ov_q <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ph_s1  <= ph_n;
			x_s1   <= x_n;
			ph_s2  <= ph_s1;
			x_s2   <= x_s1;
			va_s2  <= 32'(({31'b0, acc_q} * {31'b0, x_s1}) >> FRACTION_BITS);
			vq_s2  <= 47'(({31'b0, plan.vp} * {32'b0, x_s1}) >> FRACTION_BITS);
			ph_s3  <= ph_s2;
			va_s3  <= va_s2;
			vq_s3  <= vq_s2;
			h_s3   <= 46'(({31'b0, va_s2} * {32'b0, x_s2}) >> (FRACTION_BITS + 1));
			ph_s4  <= ph_s3;
			g_s4   <= g_n;
			vel_s4 <= v_n;
			pho_q  <= ph_s4;
			pos_q  <= sat_value(pos_n);
			velo_q <= sat_value(vel_n);
			acco_q <= sat_value(acc_n);
		end
	end

	assign out_valid    = ov_q;
	assign position     = pos_q;
	assign velocity     = velo_q;
	assign acceleration = acco_q;
	assign phase        = pho_q;

endmodule

// ===== rtl/core/tmp_checker.sv =====
`timescale 1ns / 1ps
module tmp_checker import tmp_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        cfg_write,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [31:0] position,
	input logic [31:0] velocity,
	input logic [31:0] acceleration,
	input logic [2:0]  phase
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(position) && $stable(phase))
		else $error("stalled output word changed");

	a_phase: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> phase <= PH_DONE)
		else $error("phase out of range");

	a_rest: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (phase == PH_BEFORE || phase == PH_DONE) |->
			velocity == '0 && acceleration == '0)
		else $error("motion outside profile");

	a_cruise: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && phase == PH_CRUISE |-> acceleration == '0)
		else $error("acceleration during cruise");

	a_plan: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_write |=> in_stall)
		else $error("input taken while planning");

endmodule

bind trapezoid_motion_profile_core tmp_checker u_tmp_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.cfg_write    (cfg_write),
	.in_stall     (in_stall),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.position     (position),
	.velocity     (velocity),
	.acceleration (acceleration),
	.phase        (phase)
);
